// ===== design/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by the front, queue and back modules.
package u8d_pkg;

  localparam int unsigned HeldMax  = 5;
  localparam int unsigned CmdDepth = 2;

  localparam logic [7:0] ByteAsciiEnd = 8'h80;
  localparam logic [7:0] ByteLeadMin  = 8'hC2;
  localparam logic [7:0] ByteLead3    = 8'hE0;
  localparam logic [7:0] ByteLead4    = 8'hF0;
  localparam logic [7:0] ByteLead5    = 8'hF8;
  localparam logic [7:0] ByteLead6    = 8'hFC;
  localparam logic [7:0] ByteBadMin   = 8'hFE;
  localparam logic [7:0] MinSecond3   = 8'hA0;
  localparam logic [7:0] MinSecond4   = 8'h90;
  localparam logic [7:0] MinSecond5   = 8'h88;
  localparam logic [7:0] MinSecond6   = 8'h84;
  localparam logic [1:0] ContTag      = 2'b10;

  typedef enum logic [1:0] {
    FRESH_ASCII,
    FRESH_RAW,
    FRESH_LEAD
  } fresh_e;

  typedef struct packed {
    fresh_e      kind;
    logic [2:0]  len;
    logic [4:0]  payload;
  } fresh_t;

  // One request from the front: replay of held bytes, then an optional final result.
  typedef struct packed {
    logic [2:0]            flush_cnt;
    logic [HeldMax-1:0][7:0] flush_bytes;
    logic                  has_final;
    logic [30:0]           cp;
    logic [2:0]            len;
    logic                  err;
  } cmd_t;

  function automatic fresh_t u8d_classify(input logic [7:0] b, input logic eot);
    fresh_t f;
    f.kind    = FRESH_LEAD;
    f.len     = 3'd1;
    f.payload = 5'd0;
    if (b < ByteAsciiEnd) begin
      f.kind = FRESH_ASCII;
    end else if (b < ByteLeadMin || b >= ByteBadMin || eot) begin
      f.kind = FRESH_RAW;
    end else if (b < ByteLead3) begin
      f.len = 3'd2; f.payload = b[4:0];
    end else if (b < ByteLead4) begin
      f.len = 3'd3; f.payload = {1'b0, b[3:0]};
    end else if (b < ByteLead5) begin
      f.len = 3'd4; f.payload = {2'b0, b[2:0]};
    end else if (b < ByteLead6) begin
      f.len = 3'd5; f.payload = {3'b0, b[1:0]};
    end else begin
      f.len = 3'd6; f.payload = {4'b0, b[0]};
    end
    return f;
  endfunction

  function automatic logic u8d_overlong(input logic [7:0] lead, input logic [7:0] second);
    logic r;
    r = 1'b0;
    if (lead == ByteLead3) r = second < MinSecond3;
    if (lead == ByteLead4) r = second < MinSecond4;
    if (lead == ByteLead5) r = second < MinSecond5;
    if (lead == ByteLead6) r = second < MinSecond6;
    return r;
  endfunction

endpackage

// ===== design/u8d_front.sv =====
// Front end: accepts bytes, tracks the open sequence and issues result requests.
// Depends on u8d_pkg.
module u8d_front import u8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  logic [HeldMax-1:0][7:0] held_q;
  logic [2:0]  held_count_q, held_count_d;
  logic [2:0]  exp_len_q, exp_len_d;
  logic [30:0] accum_q, accum_d;
  logic        wr_en;
  logic [2:0]  wr_idx;

  fresh_t      fr;
  logic        seq_open;
  logic        cont_ok;
  logic [30:0] accum_ext;

  always_comb begin
    fr        = u8d_classify(in_byte_i, end_of_text_i);
    seq_open  = (held_count_q != 3'd0) && (exp_len_q > held_count_q);
    cont_ok   = (in_byte_i[7:6] == ContTag) &&
                !((held_count_q == 3'd1) && u8d_overlong(held_q[0], in_byte_i));
    accum_ext = {accum_q[24:0], in_byte_i[5:0]};

    held_count_d      = held_count_q;
    exp_len_d         = exp_len_q;
    accum_d           = accum_q;
    wr_en             = 1'b0;
    wr_idx            = 3'd0;
    cmd_o.flush_cnt   = 3'd0;
    cmd_o.flush_bytes = held_q;
    cmd_o.has_final   = 1'b0;
    cmd_o.cp          = {23'd0, in_byte_i};
    cmd_o.len         = 3'd1;
    cmd_o.err         = 1'b0;

    if (!seq_open || !cont_ok) begin
      // broken or no sequence: replay what is held, then decode this byte afresh
      if (seq_open) cmd_o.flush_cnt = held_count_q;
      held_count_d = 3'd0;
      exp_len_d    = 3'd0;
      accum_d      = 31'd0;
      unique case (fr.kind)
        FRESH_ASCII: begin
          cmd_o.has_final = 1'b1;
        end
        FRESH_RAW: begin
          cmd_o.has_final = 1'b1;
          cmd_o.err       = 1'b1;
        end
        FRESH_LEAD: begin
          wr_en        = 1'b1;
          held_count_d = 3'd1;
          exp_len_d    = fr.len;
          accum_d      = {26'd0, fr.payload};
        end
        default: ;
      endcase
    end else if (held_count_q + 3'd1 == exp_len_q) begin
      cmd_o.has_final = 1'b1;
      cmd_o.cp        = accum_ext;
      cmd_o.len       = exp_len_q;
      held_count_d    = 3'd0;
      exp_len_d       = 3'd0;
      accum_d         = 31'd0;
    end else if (end_of_text_i) begin
      // truncated at end of text
      cmd_o.flush_cnt = held_count_q;
      cmd_o.has_final = 1'b1;
      cmd_o.err       = 1'b1;
      held_count_d    = 3'd0;
      exp_len_d       = 3'd0;
      accum_d         = 31'd0;
    end else begin
      wr_en        = 1'b1;
      wr_idx       = held_count_q;
      held_count_d = held_count_q + 3'd1;
      accum_d      = accum_ext;
    end

    cmd_valid_o = (cmd_o.flush_cnt != 3'd0) || cmd_o.has_final;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= 3'd0;
      exp_len_q    <= 3'd0;
      accum_q      <= 31'd0;
    end else if (take_i) begin
      held_count_q <= held_count_d;
      exp_len_q    <= exp_len_d;
      accum_q      <= accum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && wr_en) begin
      held_q[wr_idx] <= in_byte_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count_q <= 3'(HeldMax))
    else $error("held byte count out of range");

  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && end_of_text_i) |=> (held_count_q == 3'd0))
    else $error("sequence still open after end of text");
`endif

endmodule

// ===== design/u8d_cmd_fifo.sv =====
// Two-entry request queue between the front and the back end.
// Depends on u8d_pkg.
module u8d_cmd_fifo import u8d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output logic valid_o,
  output cmd_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(CmdDepth);

  cmd_t            slot_q [CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o    = count_q == (PtrW+1)'(CmdDepth);
  assign valid_o   = count_q != '0;
  assign rd_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (wr_i && !rd_i)      count_q <= count_q + 1'b1;
      else if (!wr_i && rd_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) slot_q[wr_ptr_q] <= wr_data_i;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o))
    else $error("request queue overflow");
`endif

endmodule

// ===== design/u8d_back.sv =====
// Back end: plays out one request as a series of results, one per pop.
// Depends on u8d_pkg.
module u8d_back import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_done_o,
  output logic        empty,
  input  logic        pop,
  output logic [30:0] code_point_o,
  output logic [2:0]  seq_bytes_o,
  output logic        raw_error_o,
  output logic        last_of_run_o
);

  logic [2:0] idx_q;
  logic       in_flush;
  logic [7:0] flush_byte;
  logic       take;

  always_comb begin
    in_flush   = idx_q < cmd_i.flush_cnt;
    flush_byte = cmd_i.flush_bytes[idx_q];
    if (in_flush) begin
      code_point_o  = {23'd0, flush_byte};
      seq_bytes_o   = 3'd1;
      raw_error_o   = flush_byte[7];
      last_of_run_o = (idx_q == cmd_i.flush_cnt - 3'd1) && !cmd_i.has_final;
    end else begin
      code_point_o  = cmd_i.cp;
      seq_bytes_o   = cmd_i.len;
      raw_error_o   = cmd_i.err;
      last_of_run_o = 1'b1;
    end
  end

  assign empty      = !cmd_valid_i;
  assign take       = pop && cmd_valid_i;
  assign cmd_done_o = take && last_of_run_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else if (take) begin
      idx_q <= last_of_run_o ? 3'd0 : idx_q + 3'd1;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> (idx_q < cmd_i.flush_cnt || (idx_q == cmd_i.flush_cnt && cmd_i.has_final)))
    else $error("replay index past end of request");

  a_idx_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_done_o |=> (idx_q == 3'd0))
    else $error("replay index not rewound after request");
`endif

endmodule

// ===== design/utf8_stream_decoder.sv =====
// Top level of the 31-bit, one-to-six byte UTF-8 stream decoder.
// Depends on u8d_pkg, u8d_front, u8d_cmd_fifo and u8d_back.

// Bytes enter through a queue-style port (push/full) and code points leave
// through another (empty/pop). The front end takes one byte per cycle as long
// as its two-entry request queue has room; a byte that only extends an open
// sequence makes no request. The back end gives one result per cycle, so a
// byte that causes n results (a decoded code point is one, an error replays up
// to five held bytes raw, then the breaking byte unless it opens a sequence)
// holds the output for n pops; long error bursts back up into full. The last
// result of each byte carries last_of_run; raw_error marks raw bytes >= 0x80.
module utf8_stream_decoder import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_text_i,
  output logic        empty,
  input  logic        pop,
  output logic [30:0] code_point_o,
  output logic [2:0]  seq_bytes_o,
  output logic        raw_error_o,
  output logic        last_of_run_o
);

  logic take;
  logic req_valid;
  cmd_t req;
  logic head_valid;
  cmd_t head;
  logic head_done;

  assign take = push && !full;

  u8d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .in_byte_i    (in_byte_i),
    .end_of_text_i(end_of_text_i),
    .cmd_valid_o  (req_valid),
    .cmd_o        (req)
  );

  u8d_cmd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (take && req_valid),
    .wr_data_i(req),
    .full_o   (full),
    .rd_i     (head_done),
    .valid_o  (head_valid),
    .rd_data_o(head)
  );

  u8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (head_valid),
    .cmd_i        (head),
    .cmd_done_o   (head_done),
    .empty        (empty),
    .pop          (pop),
    .code_point_o (code_point_o),
    .seq_bytes_o  (seq_bytes_o),
    .raw_error_o  (raw_error_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for utf8_stream_decoder (31-bit, 1..6 byte UTF-8).
// Depends on u8d_pkg and the decoder RTL; a directed table, then random
// byte streams, are checked against a behavioral decoder kept in this file.
`timescale 1ns / 1ps

module testbench import u8d_pkg::*;;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned RandomBytes   = 132;
  localparam int unsigned NumDirected   = 28;

  typedef struct {
    logic [30:0] cp;
    logic [2:0]  len;
    logic        err;
    logic        fin;
  } decoded_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eot;
    logic        typed;
    logic [30:0] cp;
    logic        err;
  } stim_row_t;

  // Typed rows give a single raw or ASCII result; the rest go through the predictor.
  localparam stim_row_t DirectedRows [NumDirected] = '{
    '{8'h00, 1'b0, 1'b1, 31'h00, 1'b0},
    '{8'h7F, 1'b0, 1'b1, 31'h7F, 1'b0},
    '{8'h80, 1'b0, 1'b1, 31'h80, 1'b1},
    '{8'hC1, 1'b0, 1'b1, 31'hC1, 1'b1},
    '{8'hFF, 1'b0, 1'b1, 31'hFF, 1'b1},
    '{8'hFE, 1'b0, 1'b1, 31'hFE, 1'b1},
    '{8'hC3, 1'b1, 1'b1, 31'hC3, 1'b1},   // lead cut off by end of text
    '{8'hC2, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hE0, 1'b0, 1'b0, 31'h0, 1'b0},    // overlong three-byte form
    '{8'h9F, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hFD, 1'b0, 1'b0, 31'h0, 1'b0},    // largest code point
    '{8'hBF, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hFC, 1'b0, 1'b0, 31'h0, 1'b0},    // overlong six-byte form
    '{8'h83, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 31'h0, 1'b0},    // continuation cut off by end of text
    '{8'h9F, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'h98, 1'b1, 1'b0, 31'h0, 1'b0},
    '{8'hFD, 1'b0, 1'b0, 31'h0, 1'b0},    // five held bytes, then a missing continuation
    '{8'h80, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 31'h0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 31'h0, 1'b0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        push          = 1'b0;
  logic        pop           = 1'b0;
  logic [7:0]  in_byte_i     = 8'h00;
  logic        end_of_text_i = 1'b0;
  logic        full;
  logic        empty;
  logic [30:0] code_point_o;
  logic [2:0]  seq_bytes_o;
  logic        raw_error_o;
  logic        last_of_run_o;

  utf8_stream_decoder i_dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .in_byte_i,
    .end_of_text_i,
    .empty,
    .pop,
    .code_point_o,
    .seq_bytes_o,
    .raw_error_o,
    .last_of_run_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Decoder state as the predictor sees it
  logic [7:0]  held [HeldMax];
  int unsigned held_cnt = 0;
  int unsigned seq_len  = 0;
  logic [30:0] accum    = '0;

  decoded_t    step_results [$];
  decoded_t    due_results  [$];

  // Attributes of the byte now on the request port
  logic        row_typed = 1'b0;
  logic [30:0] row_cp    = '0;
  logic        row_err   = 1'b0;

  logic        steady      = 1'b0;
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function void emit(logic [30:0] cp, logic [2:0] len, logic err);
    decoded_t d;
    d.cp  = cp;
    d.len = len;
    d.err = err;
    d.fin = 1'b0;
    step_results.push_back(d);
  endfunction

  function void drop_seq();
    held_cnt = 0;
    seq_len  = 0;
    accum    = '0;
  endfunction

  function void replay_held();
    for (int unsigned i = 0; i < held_cnt && i < HeldMax; i++)
      emit({23'd0, held[i]}, 3'd1, held[i] >= 8'h80);
    drop_seq();
  endfunction

  function void open_or_emit(logic [7:0] b, logic eot);
    if (b < ByteAsciiEnd) begin
      emit({23'd0, b}, 3'd1, 1'b0);
    end else if (b < ByteLeadMin || b >= ByteBadMin || eot) begin
      emit({23'd0, b}, 3'd1, 1'b1);
    end else begin
      if (b < ByteLead3) begin
        seq_len = 2; accum = {26'd0, b[4:0]};
      end else if (b < ByteLead4) begin
        seq_len = 3; accum = {27'd0, b[3:0]};
      end else if (b < ByteLead5) begin
        seq_len = 4; accum = {28'd0, b[2:0]};
      end else if (b < ByteLead6) begin
        seq_len = 5; accum = {29'd0, b[1:0]};
      end else begin
        seq_len = 6; accum = {30'd0, b[0]};
      end
      held[0]  = b;
      held_cnt = 1;
    end
  endfunction

  function logic too_short(logic [7:0] lead, logic [7:0] second);
    case (lead)
      ByteLead3: return second < MinSecond3;
      ByteLead4: return second < MinSecond4;
      ByteLead5: return second < MinSecond5;
      ByteLead6: return second < MinSecond6;
      default:   return 1'b0;
    endcase
  endfunction

  // Results caused by one byte land in step_results; last_of_run is set here.
  function void decode_step(logic [7:0] b, logic eot);
    logic cont_ok;
    step_results.delete();
    if (held_cnt == 0 || held_cnt > HeldMax || seq_len <= held_cnt) begin
      drop_seq();
      open_or_emit(b, eot);
    end else begin
      cont_ok = (b[7:6] == ContTag);
      if (cont_ok && held_cnt == 1 && too_short(held[0], b)) cont_ok = 1'b0;
      if (!cont_ok) begin
        replay_held();
        open_or_emit(b, eot);
      end else begin
        accum = {accum[24:0], b[5:0]};
        if (held_cnt + 1 == seq_len) begin
          emit(accum, seq_len[2:0], 1'b0);
          drop_seq();
        end else if (eot) begin
          replay_held();
          emit({23'd0, b}, 3'd1, 1'b1);
        end else begin
          held[held_cnt] = b;
          held_cnt++;
        end
      end
    end
    if (eot) drop_seq();
    if (step_results.size() > 0) step_results[step_results.size() - 1].fin = 1'b1;
  endfunction

  function void accept_byte(logic [7:0] b, logic eot);
    decoded_t d;
    decode_step(b, eot);
    if (row_typed) begin
      d.cp  = row_cp;
      d.len = 3'd1;
      d.err = row_err;
      d.fin = 1'b1;
      due_results.push_back(d);
    end else begin
      foreach (step_results[i]) due_results.push_back(step_results[i]);
    end
  endfunction

  function void check_result();
    decoded_t d;
    if (due_results.size() == 0) begin
      $error("unexpected result: code_point %h seq_bytes %0d", code_point_o, seq_bytes_o);
      mismatches++;
    end else begin
      d = due_results.pop_front();
      if (code_point_o !== d.cp) begin
        $error("code_point: expected %h, got %h", d.cp, code_point_o);
        mismatches++;
      end
      if (seq_bytes_o !== d.len) begin
        $error("seq_bytes: expected %0d, got %0d", d.len, seq_bytes_o);
        mismatches++;
      end
      if (raw_error_o !== d.err) begin
        $error("raw_error: expected %b, got %b", d.err, raw_error_o);
        mismatches++;
      end
      if (last_of_run_o !== d.fin) begin
        $error("last_of_run: expected %b, got %b", d.fin, last_of_run_o);
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) accept_byte(in_byte_i, end_of_text_i);
      if (pop && !empty) check_result();
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Output side: random back-pressure, off during steady stretches
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_left > 0 && !steady) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot, input logic typed,
                           input logic [30:0] cp, input logic err);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push          <= 1'b1;
    in_byte_i     <= b;
    end_of_text_i <= eot;
    row_typed = typed;
    row_cp    = cp;
    row_err   = err;
    do @(posedge clk_i); while (full);
  endtask

  // Mostly well-formed sequences with random payload, some damaged, some pure noise.
  task automatic send_random_seq(inout int unsigned sent);
    logic [7:0]  seq_buf [6];
    logic [31:0] lo, hi, cp;
    logic [7:0]  prefix;
    int unsigned n, r, eot_pos;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      n = $urandom_range(1, 4);
      for (int unsigned k = 0; k < n; k++) seq_buf[k] = 8'($urandom_range(0, 255));
      eot_pos = ($urandom_range(0, 9) == 0) ? n - 1 : 6;
    end else begin
      if (r < 35)      n = 1;
      else if (r < 52) n = 2;
      else if (r < 68) n = 3;
      else if (r < 80) n = 4;
      else if (r < 90) n = 5;
      else             n = 6;
      case (n)
        1: begin lo = 32'h0;       hi = 32'h7F;       prefix = 8'h00; end
        2: begin lo = 32'h80;      hi = 32'h7FF;      prefix = 8'hC0; end
        3: begin lo = 32'h800;     hi = 32'hFFFF;     prefix = 8'hE0; end
        4: begin lo = 32'h10000;   hi = 32'h1FFFFF;   prefix = 8'hF0; end
        5: begin lo = 32'h200000;  hi = 32'h3FFFFFF;  prefix = 8'hF8; end
        default: begin lo = 32'h4000000; hi = 32'h7FFFFFFF; prefix = 8'hFC; end
      endcase
      // bias some code points toward the bottom of their length class
      if ($urandom_range(0, 3) == 0) cp = lo + $urandom_range(0, 63);
      else                           cp = lo + ($urandom % (hi - lo + 1));
      if (n == 1) begin
        seq_buf[0] = cp[7:0];
      end else begin
        seq_buf[0] = prefix | 8'(cp >> (6 * (n - 1)));
        for (int unsigned k = 1; k < n; k++)
          seq_buf[k] = 8'h80 | {2'b00, 6'(cp >> (6 * (n - 1 - k)))};
      end
      case ($urandom_range(0, 7))
        0: seq_buf[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
        1: n = $urandom_range(1, n);
        2: if (n >= 3) begin
          seq_buf[0] = prefix;
          seq_buf[1] = 8'h80 | 8'($urandom_range(0, 63));
        end
        default: ;
      endcase
      if ($urandom_range(0, 7) == 0)       eot_pos = n - 1;
      else if ($urandom_range(0, 19) == 0) eot_pos = $urandom_range(0, n - 1);
      else                                 eot_pos = 6;
    end
    for (int unsigned k = 0; k < n; k++)
      send_byte(seq_buf[k], k == eot_pos, 1'b0, 31'd0, 1'b0);
    sent += n;
  endtask

  initial begin
    int unsigned sent;
    sent = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned i = 0; i < NumDirected; i++)
      send_byte(DirectedRows[i].data, DirectedRows[i].eot, DirectedRows[i].typed,
                DirectedRows[i].cp, DirectedRows[i].err);

    while (sent < RandomBytes) begin
      steady = ($urandom_range(0, 4) == 0);
      send_random_seq(sent);
    end

    @(negedge clk_i);
    push   <= 1'b0;
    steady = 1'b1;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
